// ===== src/dsts_pkg.sv =====
package dsts_pkg;

   localparam int HOUR_W     = 5;
   localparam int MINUTE_W   = 6;
   localparam int SRC_W      = 3;
   localparam int CMD_W      = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int REQ_DATA_W = 16;

   // registers in the schedule register file
   localparam int REG_SLOT_NUM = 5;
   localparam logic [CSR_ADDR_W-1:0] REG_MANUAL = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_ENABLE = 3'd6;

   // active source codes
   localparam logic [SRC_W-1:0] SRC_NONE      = 3'd0;
   localparam logic [SRC_W-1:0] SRC_MANUAL    = 3'd1;
   localparam logic [SRC_W-1:0] SRC_SLOT_BASE = 3'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE       = 2'd0,
      CMD_ON_SLOT    = 2'd1,
      CMD_OFF_MANUAL = 2'd2,
      CMD_OFF_SLOT   = 2'd3
   } cmd_type;

   // one time-update transaction, last field in the lowest bits
   typedef struct packed {
      logic                manual_start;
      logic                actuator_on;
      logic [MINUTE_W-1:0] minute_now;
      logic [HOUR_W-1:0]   hour_now;
      logic                time_updated;
   } req_item_type;

endpackage

// ===== src/dsts_csr_regs.sv =====
module dsts_csr_regs
   import dsts_pkg::*;
#(
   parameter int DURATION_BITS = 16,
   localparam int SLOT_W = DURATION_BITS + HOUR_W + MINUTE_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [CSR_ADDR_W-1:0]    wr_index,
   input  logic [SLOT_W-1:0]        wr_data,
   output logic [SLOT_W-1:0]        slot_reg [REG_SLOT_NUM],
   output logic [DURATION_BITS-1:0] manual_duration,
   output logic                     channel_enable
);

   logic [SLOT_W-1:0]        slot_ff [REG_SLOT_NUM];
   logic [DURATION_BITS-1:0] manual_ff;
   logic                     enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_SLOT_NUM; i++) begin
            slot_ff[i] <= '0;
         end
         manual_ff <= '0;
         enable_ff <= 1'b0;
      end else if (wr_en) begin
         for (int i = 0; i < REG_SLOT_NUM; i++) begin
            if (wr_index == CSR_ADDR_W'(i)) begin
               slot_ff[i] <= wr_data;
            end
         end
         unique case (wr_index)
            REG_MANUAL: manual_ff <= wr_data[DURATION_BITS-1:0];
            REG_ENABLE: enable_ff <= wr_data[0];
            default: ;
         endcase
      end
   end

   assign slot_reg        = slot_ff;
   assign manual_duration = manual_ff;
   assign channel_enable  = enable_ff;

endmodule

// ===== src/dsts_step.sv =====
module dsts_step
   import dsts_pkg::*;
#(
   parameter int SLOT_COUNT = 5,
   parameter int DURATION_BITS = 16,
   localparam int SLOT_W  = DURATION_BITS + HOUR_W + MINUTE_W,
   localparam int COUNT_W = DURATION_BITS + 1
) (
   input  req_item_type             item,
   input  logic [SRC_W-1:0]         source_cur,
   input  logic [COUNT_W-1:0]       count_cur,
   input  logic [SLOT_W-1:0]        slot_reg [REG_SLOT_NUM],
   input  logic [DURATION_BITS-1:0] manual_duration,
   input  logic                     channel_enable,
   output cmd_type                  command,
   output logic [SRC_W-1:0]         source_nxt,
   output logic [COUNT_W-1:0]       count_nxt
);

   localparam int USED_SLOTS = (SLOT_COUNT < REG_SLOT_NUM) ? SLOT_COUNT : REG_SLOT_NUM;

   logic [SRC_W-1:0]         src;
   logic [COUNT_W-1:0]       cnt;
   logic [COUNT_W-1:0]       cnt_inc;
   logic [DURATION_BITS-1:0] limit;
   logic                     hit;
   cmd_type                  off_cmd;

   always_comb begin
      src     = item.manual_start ? SRC_MANUAL : source_cur;
      cnt     = item.manual_start ? '0 : count_cur;
      command = CMD_NONE;
      hit     = 1'b0;
      limit   = '0;
      off_cmd = CMD_OFF_SLOT;
      cnt_inc = (&cnt) ? cnt : cnt + COUNT_W'(1);

      if (item.time_updated && channel_enable) begin
         if (!item.actuator_on) begin
            // last matching slot wins
            for (int i = 0; i < USED_SLOTS; i++) begin
               if (slot_reg[i][DURATION_BITS-1:0] != '0 &&
                   slot_reg[i][SLOT_W-1 -: HOUR_W] == item.hour_now &&
                   slot_reg[i][DURATION_BITS +: MINUTE_W] == item.minute_now) begin
                  hit = 1'b1;
                  src = SRC_W'(SRC_SLOT_BASE + SRC_W'(i));
               end
            end
            if (hit) begin
               cnt     = '0;
               command = CMD_ON_SLOT;
            end
         end else if (src != SRC_NONE) begin
            if (src == SRC_MANUAL) begin
               limit   = manual_duration;
               off_cmd = CMD_OFF_MANUAL;
            end else begin
               // a source with no live slot behind it expires at once
               for (int j = 0; j < USED_SLOTS; j++) begin
                  if (src == SRC_W'(SRC_SLOT_BASE + SRC_W'(j))) begin
                     limit = slot_reg[j][DURATION_BITS-1:0];
                  end
               end
            end
            cnt = cnt_inc;
            if (cnt > COUNT_W'(limit)) begin
               cnt     = '0;
               src     = SRC_NONE;
               command = off_cmd;
            end
         end
      end

      source_nxt = src;
      count_nxt  = cnt;
   end

endmodule

// ===== src/daily_slot_timer_switch_unit.sv =====
// Channel  Handshake             Payload
// req_     req_tvalid/tready     time update: tick, hour, minute, actuator state, manual start
// rsp_     rsp_tvalid/tready     command, active source, elapsed count
// csr_     csr_valid/ready       register index and write data, always ready
//
// Each transaction passes through the input register and then the result
// register; one transaction per cycle is sustained while the result side is ready,
// set by the combinational step logic that updates the source and count registers.
// Synchronous active-high reset clears the schedule, source and count.
// A stalled result holds the step; the input register still takes a transaction
// when it is empty.
module daily_slot_timer_switch_unit
   import dsts_pkg::*;
#(
   parameter int SLOT_COUNT = 5,
   parameter int DURATION_BITS = 16,
   localparam int CSR_DATA_W = DURATION_BITS + HOUR_W + MINUTE_W,
   localparam int COUNT_W    = DURATION_BITS + 1,
   localparam int RSP_BITS   = CMD_W + SRC_W + COUNT_W,
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // time_updated, hour_now, minute_now, actuator_on, manual_start, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // command, active_source_out, elapsed_out, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ITEM_W = $bits(req_item_type);

   logic [CSR_DATA_W-1:0]    slot_reg [REG_SLOT_NUM];
   logic [DURATION_BITS-1:0] manual_duration;
   logic                     channel_enable;

   logic                     in_valid_ff;
   req_item_type             in_item_ff;
   logic                     out_valid_ff;
   logic [RSP_DATA_W-1:0]    out_data_ff;
   logic [SRC_W-1:0]         source_ff;
   logic [COUNT_W-1:0]       count_ff;

   cmd_type                  command;
   logic [SRC_W-1:0]         source_in;
   logic [COUNT_W-1:0]       count_in;
   logic                     advance;

   assign csr_ready = 1'b1;

   dsts_csr_regs #(
      .DURATION_BITS(DURATION_BITS)
   ) u_csr_regs (
      .clock           (clock),
      .reset           (reset),
      .wr_en           (csr_valid),
      .wr_index        (csr_index),
      .wr_data         (csr_wdata),
      .slot_reg        (slot_reg),
      .manual_duration (manual_duration),
      .channel_enable  (channel_enable)
   );

   dsts_step #(
      .SLOT_COUNT    (SLOT_COUNT),
      .DURATION_BITS (DURATION_BITS)
   ) u_step (
      .item            (in_item_ff),
      .source_cur      (source_ff),
      .count_cur       (count_ff),
      .slot_reg        (slot_reg),
      .manual_duration (manual_duration),
      .channel_enable  (channel_enable),
      .command         (command),
      .source_nxt      (source_in),
      .count_nxt       (count_in)
   );

   // step only when the result register is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         source_ff    <= SRC_NONE;
         count_ff     <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            source_ff    <= source_in;
            count_ff     <= count_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_tdata[ITEM_W-1:0];
      end
      if (advance) begin
         out_data_ff <= RSP_DATA_W'({count_in, source_in, command});
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== sim/daily_slot_timer_switch_checker.sv =====
`timescale 1ns / 100ps

module daily_slot_timer_switch_checker
   import dsts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // time_updated, hour_now, minute_now, actuator_on, manual_start, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // command, active_source_out, elapsed_out, zero pad
   input  logic [23:0]           rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [26:0]           csr_wdata,
   output int                    mismatches,
   output int                    due_count
);

   localparam int DUR_W   = 16;
   localparam int COUNT_W = DUR_W + 1;

   typedef struct packed {
      logic [COUNT_W-1:0] elapsed;
      logic [SRC_W-1:0]   source;
      cmd_type            command;
   } switch_result_type;

   logic [26:0]        slot_word [REG_SLOT_NUM];
   logic [DUR_W-1:0]   manual_ticks;
   logic               channel_on;
   logic [SRC_W-1:0]   source_now;
   logic [COUNT_W-1:0] ticks_elapsed;

   switch_result_type switch_results_due [$];
   switch_result_type seen;
   switch_result_type want;

   // advance the schedule state by one time update and return the reported result
   function automatic switch_result_type step_schedule(input req_item_type upd);
      switch_result_type res;
      cmd_type           cmd;
      cmd_type           off_cmd;
      logic [COUNT_W-1:0] limit;
      logic              hit;
      int                k;
      cmd = CMD_NONE;
      if (upd.manual_start) begin
         source_now = SRC_MANUAL;
         ticks_elapsed = '0;
      end
      if (upd.time_updated && channel_on) begin
         if (!upd.actuator_on) begin
            hit = 1'b0;
            // the last matching slot wins
            for (int i = 0; i < REG_SLOT_NUM; i++) begin
               if (slot_word[i][DUR_W-1:0] != '0 &&
                   slot_word[i][26:22] == upd.hour_now &&
                   slot_word[i][21:16] == upd.minute_now) begin
                  hit = 1'b1;
                  source_now = SRC_SLOT_BASE + SRC_W'(i);
               end
            end
            if (hit) begin
               ticks_elapsed = '0;
               cmd = CMD_ON_SLOT;
            end
         end else if (source_now != SRC_NONE) begin
            limit = '0;
            off_cmd = CMD_OFF_SLOT;
            if (source_now == SRC_MANUAL) begin
               limit = COUNT_W'(manual_ticks);
               off_cmd = CMD_OFF_MANUAL;
            end else begin
               k = int'(source_now) - int'(SRC_SLOT_BASE);
               if (k < REG_SLOT_NUM)
                  limit = COUNT_W'(slot_word[k][DUR_W-1:0]);
            end
            if (ticks_elapsed != '1)
               ticks_elapsed = ticks_elapsed + 1'b1;
            if (ticks_elapsed > limit) begin
               ticks_elapsed = '0;
               source_now = SRC_NONE;
               cmd = off_cmd;
            end
         end
      end
      res.command = cmd;
      res.source = source_now;
      res.elapsed = ticks_elapsed;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_SLOT_NUM; i++)
            slot_word[i] = '0;
         manual_ticks = '0;
         channel_on = 1'b0;
         source_now = SRC_NONE;
         ticks_elapsed = '0;
         switch_results_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index < REG_SLOT_NUM)
               slot_word[csr_index] = csr_wdata;
            else if (csr_index == REG_MANUAL)
               manual_ticks = csr_wdata[DUR_W-1:0];
            else if (csr_index == REG_ENABLE)
               channel_on = csr_wdata[0];
         end
         // pop before push: a result never belongs to a transaction of the same edge
         if (rsp_tvalid && rsp_tready) begin
            seen = switch_result_type'(rsp_tdata[$bits(switch_result_type)-1:0]);
            if (switch_results_due.size() == 0) begin
               $error("result with no time update outstanding: tdata %h", rsp_tdata);
               mismatches++;
            end else begin
               want = switch_results_due.pop_front();
               if (seen.command !== want.command) begin
                  $error("command: expected %0d, actual %0d", want.command, seen.command);
                  mismatches++;
               end
               if (seen.source !== want.source) begin
                  $error("active_source_out: expected %0d, actual %0d",
                         want.source, seen.source);
                  mismatches++;
               end
               if (seen.elapsed !== want.elapsed) begin
                  $error("elapsed_out: expected %0d, actual %0d", want.elapsed, seen.elapsed);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            switch_results_due.push_back(
               step_schedule(req_item_type'(req_tdata[$bits(req_item_type)-1:0])));
      end
      due_count = switch_results_due.size();
   end

endmodule

// ===== sim/daily_slot_timer_switch_unit_test.sv =====
`timescale 1ns / 100ps

module daily_slot_timer_switch_unit_test;
   import dsts_pkg::*;

   localparam int CSR_W       = 27;
   localparam int RSP_W       = 24;
   localparam int LONG_HOLD   = 300;
   localparam int CYCLE_LIMIT = 200000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   int          mismatches;
   int          due_count;
   int          cycle_count = 0;
   bit          tx_burst = 1'b0;
   bit          rx_burst = 1'b0;
   bit          hold_rx = 1'b0;
   logic [26:0] plan_slot [REG_SLOT_NUM];

   daily_slot_timer_switch_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   daily_slot_timer_switch_checker checker_0 (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .due_count  (due_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic req_item_type time_update(input bit tick, input int hour,
                                                input int minute, input bit on,
                                                input bit manual);
      req_item_type upd;
      upd.time_updated = tick;
      upd.hour_now = HOUR_W'(hour);
      upd.minute_now = MINUTE_W'(minute);
      upd.actuator_on = on;
      upd.manual_start = manual;
      return upd;
   endfunction

   function automatic logic [CSR_W-1:0] slot_entry(input int hour, input int minute,
                                                   input int ticks);
      return {5'(hour), 6'(minute), 16'(ticks)};
   endfunction

   task automatic send_item(input req_item_type upd);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'(upd);
      do @(posedge clock); while (!req_tready);
   endtask

   // keep csr_valid high across back-to-back writes; the caller drops it
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] index, input logic [CSR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (index < REG_SLOT_NUM)
         plan_slot[index] = value;
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (due_count != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic int pick_ticks();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 0;
      if (r == 1)
         return 16'hFFFF;
      return $urandom_range(1, 6);
   endfunction

   task automatic program_phase(input int phase);
      logic [CSR_W-1:0] word;
      int               hour;
      int               minute;
      for (int k = 0; k < REG_SLOT_NUM; k++) begin
         hour = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
         minute = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
         word = slot_entry(hour, minute, pick_ticks());
         // share a time with the previous slot now and then
         if (k != 0 && $urandom_range(0, 3) == 0)
            word[26:16] = plan_slot[k-1][26:16];
         if (phase == 1)
            word = '1;
         else if (phase == 2)
            word = '0;
         write_reg(CSR_ADDR_W'(k), word);
      end
      if (phase == 1)
         write_reg(REG_MANUAL, CSR_W'(16'hFFFF));
      else if (phase == 2)
         write_reg(REG_MANUAL, '0);
      else
         write_reg(REG_MANUAL, CSR_W'(pick_ticks()));
      write_reg(REG_ENABLE, CSR_W'(phase == 2 ? 0 : ($urandom_range(0, 5) != 0)));
      csr_valid <= 1'b0;
   endtask

   task automatic run_sequence(inout int sent);
      int          pick;
      int          n;
      logic [26:0] word;
      pick = $urandom_range(0, 9);
      n = $urandom_range(1, 8);
      if (pick <= 7) begin
         if (pick <= 5) begin
            // slot start: off tick at a programmed time, then on ticks
            word = plan_slot[CSR_ADDR_W'($urandom_range(0, REG_SLOT_NUM-1))];
            send_item(time_update(1'b1, int'(word[26:22]), int'(word[21:16]), 1'b0,
                                  $urandom_range(0, 7) == 0));
         end else begin
            send_item(time_update(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                                  $urandom_range(0, 63), 1'($urandom_range(0, 1)), 1'b1));
         end
         sent++;
         repeat (n) begin
            send_item(time_update($urandom_range(0, 5) != 0, $urandom_range(0, 31),
                                  $urandom_range(0, 63), 1'b1, $urandom_range(0, 11) == 0));
            sent++;
         end
      end else if (pick == 8) begin
         word = plan_slot[CSR_ADDR_W'($urandom_range(0, REG_SLOT_NUM-1))];
         send_item(time_update(1'($urandom_range(0, 1)), int'(word[26:22]),
                               int'(word[21:16]), 1'($urandom_range(0, 1)),
                               $urandom_range(0, 3) == 0));
         sent++;
      end else begin
         send_item(time_update(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                               $urandom_range(0, 63), 1'($urandom_range(0, 1)),
                               $urandom_range(0, 3) == 0));
         sent++;
      end
   endtask

   // result side
   initial begin
      int stall;
      forever begin
         if (hold_rx) begin
            hold_rx = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            stall = rx_burst ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      logic [CSR_W-1:0] directed_slots [REG_SLOT_NUM];
      int               sent;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // manual start while the channel is still disabled
      send_item(time_update(1'b1, 0, 0, 1'b0, 1'b1));
      wait_quiet();

      directed_slots[0] = slot_entry(0, 0, 3);
      directed_slots[1] = slot_entry(23, 59, 1);
      directed_slots[2] = slot_entry(31, 63, 16'hFFFF);
      directed_slots[3] = slot_entry(0, 0, 2);
      directed_slots[4] = slot_entry(12, 30, 0);
      for (int k = 0; k < REG_SLOT_NUM; k++)
         write_reg(CSR_ADDR_W'(k), directed_slots[k]);
      write_reg(REG_MANUAL, CSR_W'(2));
      write_reg(REG_ENABLE, CSR_W'(1));
      csr_valid <= 1'b0;

      // two slots share midnight: the later one takes over
      send_item(time_update(1'b1, 0, 0, 1'b0, 1'b0));
      send_item(time_update(1'b1, 12, 30, 1'b0, 1'b0));
      repeat (3) send_item(time_update(1'b1, 5, 5, 1'b1, 1'b0));
      // on with no source: left on
      send_item(time_update(1'b1, 5, 6, 1'b1, 1'b0));
      send_item(time_update(1'b1, 5, 7, 1'b1, 1'b1));
      repeat (2) send_item(time_update(1'b1, 5, 8, 1'b1, 1'b0));
      send_item(time_update(1'b1, 23, 59, 1'b0, 1'b0));
      send_item(time_update(1'b0, 31, 63, 1'b1, 1'b0));
      repeat (2) send_item(time_update(1'b1, 0, 1, 1'b1, 1'b0));
      // out-of-range time held by a slot
      send_item(time_update(1'b1, 31, 63, 1'b0, 1'b0));
      send_item(time_update(1'b1, 0, 2, 1'b1, 1'b0));
      wait_quiet();

      // shrink the active slot to zero: expires on the next tick
      write_reg(CSR_ADDR_W'(2), slot_entry(31, 63, 0));
      write_reg(REG_MANUAL, '0);
      csr_valid <= 1'b0;
      send_item(time_update(1'b1, 0, 3, 1'b1, 1'b0));
      send_item(time_update(1'b1, 0, 4, 1'b1, 1'b1));
      send_item(time_update(1'b1, 0, 0, 1'b0, 1'b1));
      wait_quiet();

      write_reg(REG_ENABLE, '0);
      csr_valid <= 1'b0;
      send_item(time_update(1'b1, 0, 0, 1'b1, 1'b0));
      wait_quiet();

      write_reg(REG_MANUAL, CSR_W'(16'hFFFF));
      write_reg(REG_ENABLE, CSR_W'(1));
      csr_valid <= 1'b0;
      send_item(time_update(1'b0, 0, 0, 1'b0, 1'b1));
      repeat (2) send_item(time_update(1'b1, 1, 1, 1'b1, 1'b0));

      for (int phase = 1; phase <= 11; phase++) begin
         wait_quiet();
         program_phase(phase);
         tx_burst = ($urandom_range(0, 3) == 0);
         rx_burst = ($urandom_range(0, 3) == 0);
         // hold the result side off while items keep coming
         if (phase == 3) begin
            tx_burst = 1'b1;
            hold_rx = 1'b1;
         end
         sent = 0;
         while (sent < 100)
            run_sequence(sent);
      end

      wait_quiet();
      if (mismatches == 0 && due_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
